FILE: design/bafd_pkg.sv
// ----------------------------------------------------------------------------
// bafd_pkg
// Shared sizes for the bitset all-different filter: domain count, value width,
// popcount width and the sort key layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bafd_pkg;

  // domain storage and value range
  localparam int MAX_DOMAINS = 32;
  localparam int TARGET_BITS = 64;

  // field widths
  localparam int VALUE_W  = 64;
  localparam int DEGREE_W = 6;
  localparam int NSUM_W   = 12;
  localparam int PC_W     = 7;

  // derived widths: domain index, domain count (0..MAX_DOMAINS)
  localparam int IDX_W = $clog2(MAX_DOMAINS);
  localparam int CNT_W = $clog2(MAX_DOMAINS + 1);

  // tiebreak key and full sort key {popcount, degree, neighbour sum}
  localparam int TKEY_W = DEGREE_W + NSUM_W;
  localparam int SKEY_W = PC_W + TKEY_W;

  // only the low TARGET_BITS bits of a domain are kept
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - TARGET_BITS);

endpackage

`default_nettype wire

FILE: design/bitset_all_different_filter_unit.sv
// ----------------------------------------------------------------------------
// bitset_all_different_filter_unit
// Counting all-different filter over bitset domains. Loads a set of domains,
// ranks them by popcount and tiebreak key, removes Hall-set values in that
// order, then returns every domain in load order with the verdict.
//
//   channel | signals                                     | dir | handshake
//   --------+---------------------------------------------+-----+-----------------
//   in      | domain_values, tiebreak_degree,             | in  | in_valid/in_stall
//           | tiebreak_neighbour_sum, last_domain         |     |
//   out     | filtered_values, filtered_count,            | out | out_valid/out_stall
//           | consistent, last_result                     |     |
//
// A request that is not last is stored while there is room. The last request of a set of n
// domains starts a pass of ranking (one compare per cycle against the key RAM),
// then scan and output, the output held while out_stall is high.
// in_stall is high for the whole pass. Reset returns to loading with an empty
// set; no memory clearing is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bitset_all_different_filter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bafd_pkg::VALUE_W-1:0]      domain_values,
  input  wire logic [bafd_pkg::DEGREE_W-1:0]     tiebreak_degree,
  input  wire logic [bafd_pkg::NSUM_W-1:0]       tiebreak_neighbour_sum,
  input  wire logic                              last_domain,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [bafd_pkg::VALUE_W-1:0]      filtered_values,
  output logic      [bafd_pkg::PC_W-1:0]         filtered_count,
  output logic                                   consistent,
  output logic                                   last_result
);

  import bafd_pkg::*;

  typedef enum logic [11:0] {
    S_LOAD = 12'b0000_0000_0001,
    S_RI   = 12'b0000_0000_0010,
    S_RL   = 12'b0000_0000_0100,
    S_RJ   = 12'b0000_0000_1000,
    S_RW   = 12'b0000_0001_0000,
    S_SO   = 12'b0000_0010_0000,
    S_SD   = 12'b0000_0100_0000,
    S_SW   = 12'b0000_1000_0000,
    S_SC   = 12'b0001_0000_0000,
    S_EA   = 12'b0010_0000_0000,
    S_EB   = 12'b0100_0000_0000,
    S_EH   = 12'b1000_0000_0000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   loaded;
  logic [CNT_W-1:0]   n_dom;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   jd;
  logic               cv;
  logic [IDX_W-1:0]   rank;
  logic [SKEY_W-1:0]  ki;
  logic [IDX_W-1:0]   d;
  logic [VALUE_W-1:0] hall;
  logic [VALUE_W-1:0] uni;
  logic [CNT_W-1:0]   pend;
  logic               ok;

  logic               in_acc;
  logic               room;
  logic [VALUE_W-1:0] in_masked;
  logic [VALUE_W-1:0] pc_in;
  logic [PC_W-1:0]    pc_out;

  logic               dom_we;
  logic [IDX_W-1:0]   dom_waddr;
  logic [VALUE_W-1:0] dom_wdata;
  logic [IDX_W-1:0]   dom_raddr;
  logic [VALUE_W-1:0] dom_rdata;
  logic               key_we;
  logic [SKEY_W-1:0]  key_wdata;
  logic [IDX_W-1:0]   key_raddr;
  logic [SKEY_W-1:0]  key_rdata;
  logic [IDX_W-1:0]   ord_rdata;

  logic               idx_last;
  logic               j_last;
  logic               ahead;
  logic [IDX_W-1:0]   rank_next;
  logic [VALUE_W-1:0] work;
  logic [PC_W-1:0]    pend_ext;

  // input side
  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (loaded < CNT_W'(MAX_DOMAINS));
  assign in_masked = domain_values & VALUE_MASK;

  // shared popcount input select
  always_comb begin
    case (state)
      S_LOAD:  pc_in = in_masked;
      S_SC:    pc_in = uni;
      default: pc_in = dom_rdata;
    endcase
  end

  bafd_popcount u_popcount (
    .value (pc_in),
    .count (pc_out)
  );

  // memory port control
  assign key_we    = in_acc && room;
  assign key_wdata = {pc_out, tiebreak_degree, tiebreak_neighbour_sum};
  assign key_raddr = (state == S_RJ) ? j : idx;

  assign work      = dom_rdata & ~hall;
  assign dom_we    = key_we || (state == S_SW);
  assign dom_waddr = (state == S_LOAD) ? loaded[IDX_W-1:0] : d;
  assign dom_wdata = (state == S_LOAD) ? in_masked : work;
  assign dom_raddr = (state == S_SD) ? ord_rdata : idx;

  bafd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DOMAINS)) u_domain_ram (
    .clk   (clk),
    .we    (dom_we),
    .waddr (dom_waddr),
    .wdata (dom_wdata),
    .raddr (dom_raddr),
    .rdata (dom_rdata)
  );

  bafd_ram #(.WIDTH(SKEY_W), .DEPTH(MAX_DOMAINS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (loaded[IDX_W-1:0]),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  bafd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_DOMAINS)) u_order_ram (
    .clk   (clk),
    .we    (state == S_RW),
    .waddr (rank_next),
    .wdata (idx),
    .raddr (idx),
    .rdata (ord_rdata)
  );

  // end-of-set tests
  assign idx_last = (CNT_W'(idx) + CNT_W'(1)) == n_dom;
  assign j_last   = (CNT_W'(j) + CNT_W'(1)) == n_dom;

  // domain jd is visited before domain idx
  always_comb begin
    logic [PC_W-1:0]   pj;
    logic [PC_W-1:0]   pi;
    logic [TKEY_W-1:0] tj;
    logic [TKEY_W-1:0] ti;
    pj = key_rdata[SKEY_W-1 -: PC_W];
    pi = ki[SKEY_W-1 -: PC_W];
    tj = key_rdata[TKEY_W-1:0];
    ti = ki[TKEY_W-1:0];
    if (pj != pi) begin
      ahead = (pj < pi);
    end else if (tj != ti) begin
      ahead = (tj > ti);
    end else begin
      ahead = (jd < idx);
    end
  end

  assign rank_next = rank + IDX_W'(cv && ahead);
  assign pend_ext  = PC_W'(pend);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      loaded    <= '0;
      out_valid <= 1'b0;
      hall      <= '0;
      uni       <= '0;
      pend      <= '0;
      cv        <= 1'b0;
    end else begin
      case (state)
        // take domains until the last one of the set
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              loaded <= loaded + CNT_W'(1);
            end
            if (last_domain) begin
              n_dom <= room ? loaded + CNT_W'(1) : loaded;
              idx   <= '0;
              state <= S_RI;
            end
          end
        end
        // rank: fetch key of domain idx
        S_RI: begin
          state <= S_RL;
        end
        S_RL: begin
          ki    <= key_rdata;
          j     <= '0;
          rank  <= '0;
          cv    <= 1'b0;
          state <= S_RJ;
        end
        // stream every key past the comparator
        S_RJ: begin
          rank <= rank_next;
          jd   <= j;
          cv   <= 1'b1;
          if (j_last) begin
            state <= S_RW;
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        // last compare, place idx at its rank
        S_RW: begin
          cv <= 1'b0;
          if (idx_last) begin
            idx   <= '0;
            hall  <= '0;
            uni   <= '0;
            pend  <= '0;
            ok    <= 1'b1;
            state <= S_SO;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_RI;
          end
        end
        // scan: order entry, then domain
        S_SO: begin
          state <= S_SD;
        end
        S_SD: begin
          d     <= ord_rdata;
          state <= S_SW;
        end
        // strip Hall values and write back
        S_SW: begin
          if (work == '0) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EA;
          end else begin
            uni   <= uni | work;
            pend  <= pend + CNT_W'(1);
            state <= S_SC;
          end
        end
        // union count against domains pending
        S_SC: begin
          if (pc_out < pend_ext) begin
            ok    <= 1'b0;
            idx   <= '0;
            state <= S_EA;
          end else begin
            if (pc_out == pend_ext) begin
              hall <= hall | uni;
              uni  <= '0;
              pend <= '0;
            end
            if (idx_last) begin
              idx   <= '0;
              state <= S_EA;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_SO;
            end
          end
        end
        // output in load order
        S_EA: begin
          state <= S_EB;
        end
        S_EB: begin
          filtered_values <= dom_rdata;
          filtered_count  <= pc_out;
          consistent      <= ok;
          last_result     <= idx_last;
          out_valid       <= 1'b1;
          state           <= S_EH;
        end
        S_EH: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (idx_last) begin
              loaded <= '0;
              state  <= S_LOAD;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_EA;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/bafd_ram.sv
// ----------------------------------------------------------------------------
// bafd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bafd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/bafd_popcount.sv
// ----------------------------------------------------------------------------
// bafd_popcount
// Shared population count unit: adder tree over one value word.
// ----------------------------------------------------------------------------
`default_nettype none

module bafd_popcount (
  input  wire logic [bafd_pkg::VALUE_W-1:0] value,
  output logic      [bafd_pkg::PC_W-1:0]    count
);

  import bafd_pkg::*;

  logic [1:0] s1 [32];
  logic [2:0] s2 [16];
  logic [3:0] s3 [8];
  logic [4:0] s4 [4];
  logic [5:0] s5 [2];

  // six levels of pairwise adds
  always_comb begin
    for (int a = 0; a < 32; a++) begin
      s1[a] = {1'b0, value[2*a]} + {1'b0, value[2*a+1]};
    end
    for (int b = 0; b < 16; b++) begin
      s2[b] = {1'b0, s1[2*b]} + {1'b0, s1[2*b+1]};
    end
    for (int c = 0; c < 8; c++) begin
      s3[c] = {1'b0, s2[2*c]} + {1'b0, s2[2*c+1]};
    end
    for (int e = 0; e < 4; e++) begin
      s4[e] = {1'b0, s3[2*e]} + {1'b0, s3[2*e+1]};
    end
    for (int f = 0; f < 2; f++) begin
      s5[f] = {1'b0, s4[2*f]} + {1'b0, s4[2*f+1]};
    end
    count = {1'b0, s5[0]} + {1'b0, s5[1]};
  end

endmodule

`default_nettype wire

FILE: tb/tb_bitset_all_different_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_bitset_all_different_filter_unit
// Self-checking bench for the bitset all-different filter. Domain requests go
// in over a valid/stall channel. A built-in model ranks each loaded set, prunes
// Hall-set values and queues the per-domain results due in load order. The
// output monitor compares every returned domain field by field. A hand-written
// table comes first, then random sets under several idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_bitset_all_different_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bafd_pkg::*;

  localparam int NUM_DIRECTED = 25;
  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 100;

  // one returned domain
  typedef struct packed {
    logic [VALUE_W-1:0] values;
    logic [PC_W-1:0]    count;
    logic               ok;
    logic               last;
  } filter_result_t;

  // one directed request; exp_* only meaningful when typed is set
  typedef struct packed {
    logic [VALUE_W-1:0]  values;
    logic [DEGREE_W-1:0] degree;
    logic [NSUM_W-1:0]   nsum;
    logic                last;
    logic                typed;
    logic [VALUE_W-1:0]  exp_values;
    logic [PC_W-1:0]     exp_count;
    logic                exp_ok;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // single-domain sets, result read off directly
    '{64'h0000_0000_0000_0000, 6'd0, 12'd0, 1'b1, 1'b1, 64'h0000_0000_0000_0000, 7'd0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 12'd4095, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64,
      1'b1},
    '{64'h0000_0000_0000_0001, 6'd0, 12'd0, 1'b1, 1'b1, 64'h0000_0000_0000_0001, 7'd1, 1'b1},
    '{64'h8000_0000_0000_0000, 6'd63, 12'd0, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 7'd1, 1'b1},
    '{64'h5555_5555_5555_5555, 6'd0, 12'd4095, 1'b1, 1'b1, 64'h5555_5555_5555_5555, 7'd32,
      1'b1},
    // Hall pair prunes the third domain
    '{64'h3, 6'd1, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h3, 6'd2, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h7, 6'd0, 12'd0, 1'b1, 1'b0, 64'h0, 7'd0, 1'b0},
    // three domains over two values
    '{64'h3, 6'd0, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h3, 6'd0, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h3, 6'd0, 12'd0, 1'b1, 1'b0, 64'h0, 7'd0, 1'b0},
    // empty domain inside a set, the rest come back untouched
    '{64'hF, 6'd3, 12'd5, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h0, 6'd0, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h1, 6'd1, 12'd1, 1'b1, 1'b0, 64'h0, 7'd0, 1'b0},
    // equal popcount: key order, then load index on a full tie
    '{64'h30, 6'd5, 12'd7, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h18, 6'd5, 12'd9, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h0C, 6'd6, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h06, 6'd5, 12'd7, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'hC0, 6'd0, 12'd0, 1'b1, 1'b0, 64'h0, 7'd0, 1'b0},
    // failure after two Hall singletons, one domain never reached
    '{64'h1, 6'd0, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h3, 6'd0, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h6, 6'd0, 12'd0, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h2, 6'd0, 12'd0, 1'b1, 1'b0, 64'h0, 7'd0, 1'b0},
    // top bits
    '{64'hC000_0000_0000_0000, 6'd63, 12'd4095, 1'b0, 1'b0, 64'h0, 7'd0, 1'b0},
    '{64'h8000_0000_0000_0001, 6'd63, 12'd4095, 1'b1, 1'b0, 64'h0, 7'd0, 1'b0}
  };

  // idle/stall mix per random phase, percent
  localparam int PHASE_SEND_IDLE  [4] = '{0, 49, 0, 28};
  localparam int PHASE_RECV_STALL [4] = '{0, 0, 49, 28};

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [VALUE_W-1:0]  domain_values;
  logic [DEGREE_W-1:0] tiebreak_degree;
  logic [NSUM_W-1:0]   tiebreak_neighbour_sum;
  logic                last_domain;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  filtered_values;
  logic [PC_W-1:0]     filtered_count;
  logic                consistent;
  logic                last_result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // model state: the set being loaded, and results owed by the block
  logic [VALUE_W-1:0]       loaded_domains [$];
  logic [TKEY_W-1:0]        loaded_keys [$];
  filter_result_t           filtered_domains_due [$];
  filter_result_t           oldest_due;

  bitset_all_different_filter_unit DUT (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .domain_values          (domain_values),
    .tiebreak_degree        (tiebreak_degree),
    .tiebreak_neighbour_sum (tiebreak_neighbour_sum),
    .last_domain            (last_domain),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .filtered_values        (filtered_values),
    .filtered_count         (filtered_count),
    .consistent             (consistent),
    .last_result            (last_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // true if loaded domain a is visited ahead of domain b
  function automatic bit visits_first(input int a, input int b);
    int pa;
    int pb;
    pa = $countones(loaded_domains[a]);
    pb = $countones(loaded_domains[b]);
    if (pa != pb) return pa < pb;
    if (loaded_keys[a] != loaded_keys[b]) return loaded_keys[a] > loaded_keys[b];
    return a < b;
  endfunction

  // rank the loaded set, prune Hall sets, queue one result per domain
  function automatic void run_filter_pass();
    int                 n;
    int                 j;
    int                 d;
    int                 pend;
    int                 visit [MAX_DOMAINS];
    logic [VALUE_W-1:0] work [MAX_DOMAINS];
    logic [VALUE_W-1:0] hall;
    logic [VALUE_W-1:0] seen;
    bit                 ok;
    filter_result_t     r;
    n = loaded_domains.size();
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && visits_first(i, visit[j-1])) begin
        visit[j] = visit[j-1];
        j--;
      end
      visit[j] = i;
      work[i]  = loaded_domains[i];
    end
    hall = '0;
    seen = '0;
    pend = 0;
    ok   = 1'b1;
    for (int i = 0; i < n && ok; i++) begin
      d = visit[i];
      work[d] = work[d] & ~hall;
      if (work[d] == '0) begin
        ok = 1'b0;
      end else begin
        seen = seen | work[d];
        pend++;
        if ($countones(seen) < pend) begin
          ok = 1'b0;
        end else if ($countones(seen) == pend) begin
          hall = hall | seen;
          seen = '0;
          pend = 0;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.values = work[i];
      r.count  = PC_W'($countones(work[i]));
      r.ok     = ok;
      r.last   = (i == n - 1);
      filtered_domains_due.insert(filtered_domains_due.size(), r);
    end
    loaded_domains.delete();
    loaded_keys.delete();
  endfunction

  // accepted request into the model; overflow domains are dropped
  function automatic void load_domain(input logic [VALUE_W-1:0] values,
                                      input logic [DEGREE_W-1:0] degree,
                                      input logic [NSUM_W-1:0] nsum, input logic last);
    if (loaded_domains.size() < MAX_DOMAINS) begin
      loaded_domains.insert(loaded_domains.size(), values & VALUE_MASK);
      loaded_keys.insert(loaded_keys.size(), {degree, nsum});
    end
    if (last) run_filter_pass();
  endfunction

  // drive one request, hold it until accepted
  task automatic send_request(input logic [VALUE_W-1:0] values,
                              input logic [DEGREE_W-1:0] degree,
                              input logic [NSUM_W-1:0] nsum, input logic last);
    bit idle;
    idle = 1'b1;
    while (idle) begin
      @(negedge clk);
      idle = send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct;
      if (idle) in_valid <= 1'b0;
    end
    in_valid               <= 1'b1;
    domain_values          <= values;
    tiebreak_degree        <= degree;
    tiebreak_neighbour_sum <= nsum;
    last_domain            <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_domain(values, degree, nsum, last);
  endtask

  // one random set of n requests; mode 0 windowed subsets, 1 raw noise,
  // 2 near-permutation (one value each plus the odd extra)
  task automatic send_random_set(input int n, input int mode);
    int                  width;
    int                  base;
    int                  kept;
    logic [VALUE_W-1:0]  window;
    logic [VALUE_W-1:0]  v;
    logic [DEGREE_W-1:0] degree;
    logic [NSUM_W-1:0]   nsum;
    kept   = (n < MAX_DOMAINS) ? n : MAX_DOMAINS;
    width  = kept + $urandom_range(0, 2);
    if (width > VALUE_W) width = VALUE_W;
    base   = $urandom_range(0, VALUE_W - width);
    window = (width == VALUE_W) ? '1 : (((64'd1 << width) - 64'd1) << base);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin
          v = {$urandom, $urandom} & window;
          if ($urandom_range(0, 1) == 0) v = v & {$urandom, $urandom};
          if (v == '0 && $urandom_range(0, 9) != 0)
            v = 64'd1 << (base + $urandom_range(0, width - 1));
        end
        1: begin
          case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
          endcase
        end
        default: begin
          v = 64'd1 << ((base + i) % VALUE_W);
          if ($urandom_range(0, 3) == 0) v = v | (64'd1 << (base + $urandom_range(0, width - 1)));
        end
      endcase
      // mostly tiny keys so ties are common
      case ($urandom_range(0, 3))
        0: begin
          degree = DEGREE_W'($urandom_range(0, 63));
          nsum   = NSUM_W'($urandom_range(0, 4095));
        end
        1: begin
          degree = $urandom_range(0, 1) ? 6'd63 : 6'd0;
          nsum   = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        end
        default: begin
          degree = DEGREE_W'($urandom_range(0, 1));
          nsum   = NSUM_W'($urandom_range(0, 2));
        end
      endcase
      send_request(v, degree, nsum, i == n - 1);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               filtered_domains_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output check against the oldest result due
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (filtered_domains_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing due, values %h", filtered_values));
      end else begin
        oldest_due = filtered_domains_due.pop_front();
        if (filtered_values !== oldest_due.values)
          report_mismatch($sformatf("filtered_values %h, want %h", filtered_values,
                                    oldest_due.values));
        if (filtered_count !== oldest_due.count)
          report_mismatch($sformatf("filtered_count %0d, want %0d", filtered_count,
                                    oldest_due.count));
        if (consistent !== oldest_due.ok)
          report_mismatch($sformatf("consistent %b, want %b", consistent, oldest_due.ok));
        if (last_result !== oldest_due.last)
          report_mismatch($sformatf("last_result %b, want %b", last_result, oldest_due.last));
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t      row;
    filter_result_t typed_result;
    int             phase_items;
    int             n;
    int             mode;
    rst                    = 1'b1;
    in_valid               = 1'b0;
    domain_values          = '0;
    tiebreak_degree        = '0;
    tiebreak_neighbour_sum = '0;
    last_domain            = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; typed rows override the model with the hand value
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      send_request(row.values, row.degree, row.nsum, row.last);
      if (row.typed) begin
        void'(filtered_domains_due.pop_back());
        typed_result = '{row.exp_values, row.exp_count, row.exp_ok, 1'b1};
        filtered_domains_due.insert(filtered_domains_due.size(), typed_result);
      end
    end

    // random sets per idle/stall phase, draining between phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = PHASE_SEND_IDLE[p];
      recv_stall_pct = PHASE_RECV_STALL[p];
      phase_items    = 0;
      while (phase_items < RANDOM_ITEMS / 4) begin
        if (phase_items == 0 && p == 0) n = MAX_DOMAINS + 2;      // overflow set
        else if (phase_items == 0 && p == 3) n = MAX_DOMAINS;     // full set
        else if ($urandom_range(0, 24) == 0) n = $urandom_range(MAX_DOMAINS, MAX_DOMAINS + 3);
        else n = $urandom_range(1, 6);
        mode = $urandom_range(0, 9);
        mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
        send_random_set(n, mode);
        phase_items += (n < MAX_DOMAINS) ? n : MAX_DOMAINS;
      end
      @(negedge clk);
      in_valid <= 1'b0;
      while (filtered_domains_due.size() != 0) @(posedge clk);
    end

    // drain, then watch for stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && filtered_domains_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
